### rtl/pk3d_pkg.sv
// shared types, constants and the sequencer program of the 3d peak finder
package pk3d_pkg;

   localparam int DENSITY_W  = 16;
   localparam int SIZE_W     = 7;
   localparam int POS_W      = 6;
   localparam int COUNT_W    = 19;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int STEP_W     = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X,
      CSR_SIZE_Y,
      CSR_SIZE_Z,
      CSR_MIN_PEAK
   } csr_idx_type;

   typedef enum logic {
      REQ_LOAD    = 1'b0,
      REQ_EXAMINE = 1'b1
   } req_kind_type;

   // neighbor offset along one axis
   typedef enum logic [1:0] {
      OFF_ZERO,
      OFF_DEC,
      OFF_INC
   } off_type;

   typedef enum logic [2:0] {
      UOP_NOP,
      UOP_SCAN_CHK,
      UOP_READ,
      UOP_LD_FIX,
      UOP_LD_WR,
      UOP_EMIT
   } uop_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_END,
      SEQ_WAIT_END
   } seq_type;

   typedef struct packed {
      uop_type op;
      logic    centre;
      off_type dx;
      off_type dy;
      off_type dz;
      seq_type seq;
   } ucode_type;

   localparam logic [STEP_W-1:0] EX_ENTRY = 6'd0;
   localparam logic [STEP_W-1:0] LD_ENTRY = 6'd32;

   function automatic ucode_type uc_ctl(input uop_type op, input seq_type seq);
      ucode_type w;
      w        = '0;
      w.op     = op;
      w.dx     = OFF_ZERO;
      w.dy     = OFF_ZERO;
      w.dz     = OFF_ZERO;
      w.seq    = seq;
      return w;
   endfunction

   function automatic ucode_type uc_rd(input off_type dx, input off_type dy,
                                       input off_type dz);
      ucode_type w;
      w        = '0;
      w.op     = UOP_READ;
      w.centre = (dx == OFF_ZERO) && (dy == OFF_ZERO) && (dz == OFF_ZERO);
      w.dx     = dx;
      w.dy     = dy;
      w.dz     = dz;
      w.seq    = SEQ_NEXT;
      return w;
   endfunction

   // examine program at 0..31, load program at 32..35
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         6'd0:  w = uc_ctl(UOP_SCAN_CHK, SEQ_NEXT);
         6'd1:  w = uc_rd(OFF_ZERO, OFF_ZERO, OFF_ZERO);
         6'd2:  w = uc_rd(OFF_DEC,  OFF_DEC,  OFF_DEC);
         6'd3:  w = uc_rd(OFF_DEC,  OFF_DEC,  OFF_ZERO);
         6'd4:  w = uc_rd(OFF_DEC,  OFF_DEC,  OFF_INC);
         6'd5:  w = uc_rd(OFF_DEC,  OFF_ZERO, OFF_DEC);
         6'd6:  w = uc_rd(OFF_DEC,  OFF_ZERO, OFF_ZERO);
         6'd7:  w = uc_rd(OFF_DEC,  OFF_ZERO, OFF_INC);
         6'd8:  w = uc_rd(OFF_DEC,  OFF_INC,  OFF_DEC);
         6'd9:  w = uc_rd(OFF_DEC,  OFF_INC,  OFF_ZERO);
         6'd10: w = uc_rd(OFF_DEC,  OFF_INC,  OFF_INC);
         6'd11: w = uc_rd(OFF_ZERO, OFF_DEC,  OFF_DEC);
         6'd12: w = uc_rd(OFF_ZERO, OFF_DEC,  OFF_ZERO);
         6'd13: w = uc_rd(OFF_ZERO, OFF_DEC,  OFF_INC);
         6'd14: w = uc_rd(OFF_ZERO, OFF_ZERO, OFF_DEC);
         6'd15: w = uc_rd(OFF_ZERO, OFF_ZERO, OFF_INC);
         6'd16: w = uc_rd(OFF_ZERO, OFF_INC,  OFF_DEC);
         6'd17: w = uc_rd(OFF_ZERO, OFF_INC,  OFF_ZERO);
         6'd18: w = uc_rd(OFF_ZERO, OFF_INC,  OFF_INC);
         6'd19: w = uc_rd(OFF_INC,  OFF_DEC,  OFF_DEC);
         6'd20: w = uc_rd(OFF_INC,  OFF_DEC,  OFF_ZERO);
         6'd21: w = uc_rd(OFF_INC,  OFF_DEC,  OFF_INC);
         6'd22: w = uc_rd(OFF_INC,  OFF_ZERO, OFF_DEC);
         6'd23: w = uc_rd(OFF_INC,  OFF_ZERO, OFF_ZERO);
         6'd24: w = uc_rd(OFF_INC,  OFF_ZERO, OFF_INC);
         6'd25: w = uc_rd(OFF_INC,  OFF_INC,  OFF_DEC);
         6'd26: w = uc_rd(OFF_INC,  OFF_INC,  OFF_ZERO);
         6'd27: w = uc_rd(OFF_INC,  OFF_INC,  OFF_INC);
         // drain the address and read pipeline
         6'd28: w = uc_ctl(UOP_NOP, SEQ_NEXT);
         6'd29: w = uc_ctl(UOP_NOP, SEQ_NEXT);
         6'd30: w = uc_ctl(UOP_NOP, SEQ_NEXT);
         6'd31: w = uc_ctl(UOP_EMIT, SEQ_WAIT_END);
         // let the grid size products settle after a register write
         6'd32: w = uc_ctl(UOP_NOP, SEQ_NEXT);
         6'd33: w = uc_ctl(UOP_NOP, SEQ_NEXT);
         6'd34: w = uc_ctl(UOP_LD_FIX, SEQ_NEXT);
         6'd35: w = uc_ctl(UOP_LD_WR, SEQ_END);
         default: w = uc_ctl(UOP_NOP, SEQ_END);
      endcase
      return w;
   endfunction

endpackage

### rtl/pk3d_if.sv
// request, response and register write channels of the 3d peak finder
interface pk3d_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [pk3d_pkg::DENSITY_W-1:0] density;

   modport source (output valid, output req_type, output density, input ready);
   modport sink   (input valid, input req_type, input density, output ready);
endinterface

interface pk3d_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         is_peak;
   logic [pk3d_pkg::POS_W-1:0]   pos_x;
   logic [pk3d_pkg::POS_W-1:0]   pos_y;
   logic [pk3d_pkg::POS_W-1:0]   pos_z;
   logic [pk3d_pkg::COUNT_W-1:0] peak_count;
   logic                         last_cell;

   modport source (output valid, output is_peak, output pos_x, output pos_y, output pos_z,
                   output peak_count, output last_cell, input ready);
   modport sink   (input valid, input is_peak, input pos_x, input pos_y, input pos_z,
                   input peak_count, input last_cell, output ready);
endinterface

interface pk3d_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pk3d_pkg::CSR_IDX_W-1:0]  index;
   logic [pk3d_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/periodic_3d_peak_finder.sv
// Periodic 3d peak finder. Load words fill the volume memory (MAX_DIM^3 samples,
// no clearing pass) in raster order, z fastest; examine words visit cells in the
// same order and each returns one response word. A small microcode program drives
// the datapath and takes no new word until the program of the last one has ended;
// an examine word also waits while the response register stays full. An
// examine word makes 27 reads (centre and 26 wrapped neighbors) through the
// single-port volume memory, behind a three-stage address and read pipeline.
module periodic_3d_peak_finder #(
   parameter int MAX_DIM     = 64,
   parameter int SAMPLE_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   pk3d_req_if.sink   req,
   pk3d_rsp_if.source rsp,
   pk3d_csr_if.sink   csr
);

   localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int SW    = $clog2(MAX_DIM + 1);
   localparam int PW    = 2 * SW;
   localparam int TW    = 3 * SW;
   localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (SAMPLE_BITS > pk3d_pkg::DENSITY_W) ? SAMPLE_BITS
                                                              : pk3d_pkg::DENSITY_W;

   function automatic logic [SW-1:0] eff_size(input logic [pk3d_pkg::SIZE_W-1:0] v);
      logic [SW-1:0] r;
      if (v == '0) begin
         r = SW'(1);
      end else if (v > MAX_DIM) begin
         r = SW'(MAX_DIM);
      end else begin
         r = SW'(v);
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] wrap_coord(input logic [CW-1:0] p,
                                                input pk3d_pkg::off_type d,
                                                input logic [SW-1:0] n);
      logic [SW:0]   up;
      logic [CW-1:0] r;
      up = (SW+1)'(p) + 1'b1;
      case (d)
         pk3d_pkg::OFF_DEC: r = (p == '0) ? CW'(n - 1'b1) : p - 1'b1;
         pk3d_pkg::OFF_INC: r = (up >= (SW+1)'(n)) ? '0 : CW'(up);
         default:           r = p;
      endcase
      return r;
   endfunction

   // configuration
   logic [pk3d_pkg::SIZE_W-1:0]    size_x_ff, size_y_ff, size_z_ff;
   logic [pk3d_pkg::DENSITY_W-1:0] min_peak_ff;
   logic [SW-1:0]                  nx, ny, nz;
   logic [PW-1:0]                  plane_ff, plane_in;
   logic [TW-1:0]                  total_ff, total_in;

   // sequencer
   logic                           busy_ff, busy_in;
   logic [pk3d_pkg::STEP_W-1:0]    step_ff, step_in;
   pk3d_pkg::ucode_type            uc;
   pk3d_pkg::uop_type              do_op;
   logic                           accept;
   logic                           out_busy;
   logic                           emit_fire;

   // scan and load state
   logic [AW-1:0]                  li_ff, li_in;
   logic [TW-1:0]                  li_wide, li_up;
   logic [CW-1:0]                  sx_ff, sy_ff, sz_ff, sx_in, sy_in, sz_in;
   logic [SW-1:0]                  x_up, y_up, z_up;
   logic [pk3d_pkg::COUNT_W-1:0]   found_ff, found_in, cnt_new;
   logic                           out_of_range;
   logic                           last;
   logic [SAMPLE_BITS-1:0]         din_ff;

   // address and read pipeline
   logic [CW-1:0]                  xa, yb, zc;
   logic [TW-1:0]                  prod_x, prod_y;
   logic                           va_ff, ca_ff, vb_ff, cb_ff, vc_ff, cc_ff;
   logic                           va_in;
   logic [AW-1:0]                  xp_ff, yp_ff, addr_ff, addr_in;
   logic [CW-1:0]                  zc_ff;
   logic [AW-1:0]                  mem_addr;
   logic                           mem_we;
   logic [SAMPLE_BITS-1:0]         mem [DEPTH];
   logic [SAMPLE_BITS-1:0]         rd_ff;
   logic [SAMPLE_BITS-1:0]         centre_ff;
   logic                           peak_ff;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           is_peak_ff;
   logic [pk3d_pkg::POS_W-1:0]     pos_x_ff, pos_y_ff, pos_z_ff;
   logic [pk3d_pkg::COUNT_W-1:0]   count_ff;
   logic                           last_ff;

   assign nx = eff_size(size_x_ff);
   assign ny = eff_size(size_y_ff);
   assign nz = eff_size(size_z_ff);

   assign plane_in = PW'(ny) * PW'(nz);
   assign total_in = TW'(nx) * TW'(plane_ff);

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff   <= pk3d_pkg::SIZE_W'(64);
         size_y_ff   <= pk3d_pkg::SIZE_W'(64);
         size_z_ff   <= pk3d_pkg::SIZE_W'(64);
         min_peak_ff <= '0;
      end else if (csr.valid && csr.ready) begin
         case (pk3d_pkg::csr_idx_type'(csr.index))
            pk3d_pkg::CSR_SIZE_X:   size_x_ff   <= csr.data[pk3d_pkg::SIZE_W-1:0];
            pk3d_pkg::CSR_SIZE_Y:   size_y_ff   <= csr.data[pk3d_pkg::SIZE_W-1:0];
            pk3d_pkg::CSR_SIZE_Z:   size_z_ff   <= csr.data[pk3d_pkg::SIZE_W-1:0];
            pk3d_pkg::CSR_MIN_PEAK: min_peak_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // grid products are registered: plane from the size registers, total from the registered plane
   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
      total_ff <= total_in;
   end

   // ---------------- sequencer ----------------
   assign uc        = pk3d_pkg::ucode_rom(step_ff);
   assign do_op     = busy_ff ? uc.op : pk3d_pkg::UOP_NOP;
   assign req.ready = !busy_ff;
   assign accept    = req.valid && req.ready;
   assign out_busy  = rsp_valid_ff && !rsp.ready;
   assign emit_fire = (do_op == pk3d_pkg::UOP_EMIT) && !out_busy;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (accept) begin
            busy_in = 1'b1;
            step_in = (req.req_type == pk3d_pkg::REQ_EXAMINE) ? pk3d_pkg::EX_ENTRY
                                                              : pk3d_pkg::LD_ENTRY;
         end
      end else begin
         case (uc.seq)
            pk3d_pkg::SEQ_NEXT:     step_in = step_ff + 1'b1;
            pk3d_pkg::SEQ_END:      busy_in = 1'b0;
            pk3d_pkg::SEQ_WAIT_END: busy_in = out_busy;
            default:                busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= pk3d_pkg::EX_ENTRY;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         din_ff <= SAMPLE_BITS'(req.density);
      end
   end

   // ---------------- scan and load counters ----------------
   assign li_wide = TW'(li_ff);
   assign li_up   = li_wide + 1'b1;
   assign x_up    = SW'(sx_ff) + 1'b1;
   assign y_up    = SW'(sy_ff) + 1'b1;
   assign z_up    = SW'(sz_ff) + 1'b1;
   assign cnt_new = found_ff + pk3d_pkg::COUNT_W'(peak_ff);

   assign out_of_range = (SW'(sx_ff) >= nx) || (SW'(sy_ff) >= ny) || (SW'(sz_ff) >= nz);
   assign last = (SW'(sx_ff) == nx - 1'b1) && (SW'(sy_ff) == ny - 1'b1)
              && (SW'(sz_ff) == nz - 1'b1);

   always_comb begin
      li_in    = li_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sz_in    = sz_ff;
      found_in = found_ff;
      case (do_op)
         pk3d_pkg::UOP_SCAN_CHK: begin
            if (out_of_range) begin
               sx_in    = '0;
               sy_in    = '0;
               sz_in    = '0;
               found_in = '0;
            end
         end
         pk3d_pkg::UOP_LD_FIX: begin
            if (li_wide >= total_ff) begin
               li_in = '0;
            end
         end
         pk3d_pkg::UOP_LD_WR: begin
            li_in = (li_up >= total_ff) ? '0 : AW'(li_up);
         end
         pk3d_pkg::UOP_EMIT: begin
            if (!out_busy) begin
               if (last) begin
                  sx_in    = '0;
                  sy_in    = '0;
                  sz_in    = '0;
                  found_in = '0;
               end else begin
                  found_in = cnt_new;
                  if (z_up < nz) begin
                     sz_in = CW'(z_up);
                  end else begin
                     sz_in = '0;
                     if (y_up < ny) begin
                        sy_in = CW'(y_up);
                     end else begin
                        sy_in = '0;
                        sx_in = CW'(x_up);
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         li_ff    <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sz_ff    <= '0;
         found_ff <= '0;
      end else begin
         li_ff    <= li_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         sz_ff    <= sz_in;
         found_ff <= found_in;
      end
   end

   // ---------------- address and read pipeline ----------------
   assign xa     = wrap_coord(sx_ff, uc.dx, nx);
   assign yb     = wrap_coord(sy_ff, uc.dy, ny);
   assign zc     = wrap_coord(sz_ff, uc.dz, nz);
   assign prod_x = TW'(xa) * TW'(plane_ff);
   assign prod_y = TW'(yb) * TW'(nz);
   assign va_in  = (do_op == pk3d_pkg::UOP_READ);

   // row and plane offsets registered, then summed into the cell address
   always_ff @(posedge clock) begin
      xp_ff <= AW'(prod_x);
      yp_ff <= AW'(prod_y);
      zc_ff <= zc;
   end

   assign addr_in = xp_ff + yp_ff + AW'(zc_ff);

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         ca_ff <= 1'b0;
         vb_ff <= 1'b0;
         cb_ff <= 1'b0;
         vc_ff <= 1'b0;
         cc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         ca_ff <= va_in && uc.centre;
         vb_ff <= va_ff;
         cb_ff <= ca_ff;
         vc_ff <= vb_ff;
         cc_ff <= cb_ff;
      end
   end

   // single port: load writes and examine reads never share a cycle
   assign mem_we   = (do_op == pk3d_pkg::UOP_LD_WR);
   assign mem_addr = mem_we ? li_ff : addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= din_ff;
      end
      rd_ff <= mem[mem_addr];
   end

   // centre arrives first, neighbors can only clear the flag
   always_ff @(posedge clock) begin
      if (vc_ff) begin
         if (cc_ff) begin
            centre_ff <= rd_ff;
            peak_ff   <= CMP_W'(rd_ff) >= CMP_W'(min_peak_ff);
         end else if (rd_ff > centre_ff) begin
            peak_ff <= 1'b0;
         end
      end
   end

   // ---------------- response register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         is_peak_ff <= peak_ff;
         pos_x_ff   <= pk3d_pkg::POS_W'(sx_ff);
         pos_y_ff   <= pk3d_pkg::POS_W'(sy_ff);
         pos_z_ff   <= pk3d_pkg::POS_W'(sz_ff);
         count_ff   <= cnt_new;
         last_ff    <= last;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.is_peak    = is_peak_ff;
   assign rsp.pos_x      = pos_x_ff;
   assign rsp.pos_y      = pos_y_ff;
   assign rsp.pos_z      = pos_z_ff;
   assign rsp.peak_count = count_ff;
   assign rsp.last_cell  = last_ff;

endmodule

### rtl/pk3d_checker.sv
// port-level checks of the 3d peak finder and their binding to the top level
module pk3d_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_type,
   input logic                         csr_valid,
   input logic                         csr_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         is_peak,
   input logic [pk3d_pkg::POS_W-1:0]   pos_x,
   input logic [pk3d_pkg::POS_W-1:0]   pos_y,
   input logic [pk3d_pkg::POS_W-1:0]   pos_z,
   input logic [pk3d_pkg::COUNT_W-1:0] peak_count,
   input logic                         last_cell
);

   logic [1:0]                   pend_ff;
   logic                         pass_start_ff;
   logic                         have_prev_ff;
   logic [pk3d_pkg::COUNT_W-1:0] prev_cnt_ff;
   logic [pk3d_pkg::COUNT_W-1:0] base_cnt;
   logic                         ex_acc;
   logic                         rsp_acc;

   assign ex_acc   = req_valid && req_ready && (req_type == pk3d_pkg::REQ_EXAMINE);
   assign rsp_acc  = rsp_valid && rsp_ready;
   assign base_cnt = pass_start_ff ? '0 : prev_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= '0;
         pass_start_ff <= 1'b1;
         have_prev_ff  <= 1'b0;
         prev_cnt_ff   <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(ex_acc) - 2'(rsp_acc);
         if (rsp_acc) begin
            pass_start_ff <= last_cell;
            have_prev_ff  <= !last_cell;
            prev_cnt_ff   <= peak_count;
         end
         // a register write may move the scan, so forget the running count
         if (csr_valid && csr_ready) begin
            have_prev_ff <= 1'b0;
         end
      end
   end

   // load words never produce a response
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("response without a pending examine word");

   // a new pass starts at the origin
   a_pass_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && pass_start_ff) |-> (pos_x == '0 && pos_y == '0 && pos_z == '0))
      else $error("first cell of a pass is not the origin");

   // running count grows by exactly the peak flag
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (pass_start_ff || have_prev_ff))
         |-> (peak_count == base_cnt + pk3d_pkg::COUNT_W'(is_peak)))
      else $error("peak count does not follow the peak flags");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid
         && $stable({is_peak, pos_x, pos_y, pos_z, peak_count, last_cell})))
      else $error("stalled response word changed");

endmodule

bind periodic_3d_peak_finder pk3d_checker u_pk3d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .req_type   (req.req_type),
   .csr_valid  (csr.valid),
   .csr_ready  (csr.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .is_peak    (rsp.is_peak),
   .pos_x      (rsp.pos_x),
   .pos_y      (rsp.pos_y),
   .pos_z      (rsp.pos_z),
   .peak_count (rsp.peak_count),
   .last_cell  (rsp.last_cell)
);

### sim/tb.sv
// testbench for the periodic 3d peak finder: load and examine traffic checked by a local predictor
`timescale 1ns / 100ps

module tb;

   localparam int GRID_MAX   = 64;
   localparam int GRID_CELLS = GRID_MAX * GRID_MAX * GRID_MAX;
   localparam int WORD_GOAL  = 1700;

   typedef struct packed {
      logic                         is_peak;
      logic [pk3d_pkg::POS_W-1:0]   pos_x;
      logic [pk3d_pkg::POS_W-1:0]   pos_y;
      logic [pk3d_pkg::POS_W-1:0]   pos_z;
      logic [pk3d_pkg::COUNT_W-1:0] peak_count;
      logic                         last_cell;
   } peak_report_type;

   typedef struct packed {
      pk3d_pkg::req_kind_type         kind;
      logic [pk3d_pkg::DENSITY_W-1:0] dens;
   } grid_word_type;

   logic clock;
   logic reset;

   pk3d_req_if req ();
   pk3d_rsp_if rsp ();
   pk3d_csr_if csr ();

   periodic_3d_peak_finder uut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // predicted block state, starting from its reset values
   logic [pk3d_pkg::DENSITY_W-1:0] volume [0:GRID_CELLS-1];
   logic [17:0]                    load_ptr    = '0;
   logic [pk3d_pkg::POS_W-1:0]     scan_x      = '0;
   logic [pk3d_pkg::POS_W-1:0]     scan_y      = '0;
   logic [pk3d_pkg::POS_W-1:0]     scan_z      = '0;
   logic [pk3d_pkg::COUNT_W-1:0]   found       = '0;
   logic [pk3d_pkg::SIZE_W-1:0]    reg_size_x  = 7'd64;
   logic [pk3d_pkg::SIZE_W-1:0]    reg_size_y  = 7'd64;
   logic [pk3d_pkg::SIZE_W-1:0]    reg_size_z  = 7'd64;
   logic [pk3d_pkg::DENSITY_W-1:0] peak_floor  = '0;

   grid_word_type   word_q[$];
   peak_report_type due_reports[$];

   int unsigned errors      = 0;
   int unsigned pushed      = 0;
   int unsigned words_taken = 0;
   int unsigned exams_taken = 0;
   int unsigned hold_left   = 0;
   bit          hold_done   = 1'b0;
   bit          req_taken   = 1'b0;
   logic        calm;

   // stretch of traffic with no idling on either side
   assign calm = (words_taken >= 600) && (words_taken < 900);

   function automatic int unsigned axis_len(logic [pk3d_pkg::SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > GRID_MAX) return GRID_MAX;
      return 32'(v);
   endfunction

   function automatic int unsigned step_axis(int unsigned p, int d, int unsigned n);
      if (d < 0) return (p == 0) ? n - 1 : p - 1;
      if (d > 0) return (p + 1 >= n) ? 0 : p + 1;
      return p;
   endfunction

   function automatic int unsigned cell_at(int unsigned x, int unsigned y, int unsigned z,
                                           int unsigned ny, int unsigned nz);
      return 32'(volume[(x * ny + y) * nz + z]);
   endfunction

   function automatic void step_grid(pk3d_pkg::req_kind_type kind,
                                     logic [pk3d_pkg::DENSITY_W-1:0] dens);
      int unsigned     nx;
      int unsigned     ny;
      int unsigned     nz;
      int unsigned     total;
      int unsigned     centre;
      bit              hit;
      bit              at_end;
      peak_report_type r;
      nx    = axis_len(reg_size_x);
      ny    = axis_len(reg_size_y);
      nz    = axis_len(reg_size_z);
      total = nx * ny * nz;
      if (kind == pk3d_pkg::REQ_LOAD) begin
         if (load_ptr >= total) load_ptr = '0;
         volume[load_ptr] = dens;
         load_ptr = (load_ptr + 1 >= total) ? '0 : load_ptr + 18'd1;
         return;
      end
      exams_taken++;
      // grid shrank under the scan: restart the pass
      if (scan_x >= nx || scan_y >= ny || scan_z >= nz) begin
         scan_x = '0;
         scan_y = '0;
         scan_z = '0;
         found  = '0;
      end
      centre = cell_at(scan_x, scan_y, scan_z, ny, nz);
      hit    = centre >= peak_floor;
      for (int dx = -1; dx <= 1; dx++)
         for (int dy = -1; dy <= 1; dy++)
            for (int dz = -1; dz <= 1; dz++)
               if (dx != 0 || dy != 0 || dz != 0)
                  if (cell_at(step_axis(scan_x, dx, nx), step_axis(scan_y, dy, ny),
                              step_axis(scan_z, dz, nz), ny, nz) > centre)
                     hit = 1'b0;
      if (hit) found = found + 1'b1;
      at_end = (scan_x == nx - 1) && (scan_y == ny - 1) && (scan_z == nz - 1);
      r.is_peak    = hit;
      r.pos_x      = scan_x;
      r.pos_y      = scan_y;
      r.pos_z      = scan_z;
      r.peak_count = found;
      r.last_cell  = at_end;
      due_reports.insert(due_reports.size(), r);
      if (at_end) begin
         scan_x = '0;
         scan_y = '0;
         scan_z = '0;
         found  = '0;
      end else if (scan_z + 1 < nz) begin
         scan_z = scan_z + 1'b1;
      end else begin
         scan_z = '0;
         if (scan_y + 1 < ny) begin
            scan_y = scan_y + 1'b1;
         end else begin
            scan_y = '0;
            scan_x = scan_x + 1'b1;
         end
      end
   endfunction

   function automatic void apply_reg(pk3d_pkg::csr_idx_type idx,
                                     logic [pk3d_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         pk3d_pkg::CSR_SIZE_X:   reg_size_x = val[pk3d_pkg::SIZE_W-1:0];
         pk3d_pkg::CSR_SIZE_Y:   reg_size_y = val[pk3d_pkg::SIZE_W-1:0];
         pk3d_pkg::CSR_SIZE_Z:   reg_size_z = val[pk3d_pkg::SIZE_W-1:0];
         pk3d_pkg::CSR_MIN_PEAK: peak_floor = val[pk3d_pkg::DENSITY_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic report_error(string msg);
      errors++;
      if (errors <= 200) $display("mismatch: %s", msg);
   endtask

   task automatic check_report();
      peak_report_type w;
      if (due_reports.size() == 0) begin
         report_error($sformatf("unexpected word at (%0d,%0d,%0d)",
                                rsp.pos_x, rsp.pos_y, rsp.pos_z));
      end else begin
         w = due_reports.pop_front();
         if (rsp.is_peak !== w.is_peak)
            report_error($sformatf("is_peak %b, want %b at (%0d,%0d,%0d)", rsp.is_peak,
                                   w.is_peak, w.pos_x, w.pos_y, w.pos_z));
         if (rsp.pos_x !== w.pos_x)
            report_error($sformatf("pos_x %0d, want %0d", rsp.pos_x, w.pos_x));
         if (rsp.pos_y !== w.pos_y)
            report_error($sformatf("pos_y %0d, want %0d", rsp.pos_y, w.pos_y));
         if (rsp.pos_z !== w.pos_z)
            report_error($sformatf("pos_z %0d, want %0d", rsp.pos_z, w.pos_z));
         if (rsp.peak_count !== w.peak_count)
            report_error($sformatf("peak_count %0d, want %0d at (%0d,%0d,%0d)",
                                   rsp.peak_count, w.peak_count, w.pos_x, w.pos_y, w.pos_z));
         if (rsp.last_cell !== w.last_cell)
            report_error($sformatf("last_cell %b, want %b at (%0d,%0d,%0d)", rsp.last_cell,
                                   w.last_cell, w.pos_x, w.pos_y, w.pos_z));
      end
   endtask

   function automatic void push_word(pk3d_pkg::req_kind_type kind,
                                     logic [pk3d_pkg::DENSITY_W-1:0] dens);
      grid_word_type w;
      w.kind = kind;
      w.dens = dens;
      word_q.insert(word_q.size(), w);
      pushed++;
   endfunction

   function automatic logic [pk3d_pkg::DENSITY_W-1:0] pick_density(
      int mode, logic [pk3d_pkg::DENSITY_W-1:0] base);
      case (mode)
         0:       return pk3d_pkg::DENSITY_W'($urandom_range(65535));
         1:       return base + pk3d_pkg::DENSITY_W'($urandom_range(2));
         default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   // size value with random junk above the register width now and then
   function automatic logic [pk3d_pkg::CSR_DATA_W-1:0] size_word(int unsigned v);
      logic [pk3d_pkg::CSR_DATA_W-1:0] d;
      d = pk3d_pkg::CSR_DATA_W'(v);
      if ($urandom_range(3) == 0)
         d[pk3d_pkg::CSR_DATA_W-1:pk3d_pkg::SIZE_W] =
            (pk3d_pkg::CSR_DATA_W - pk3d_pkg::SIZE_W)'($urandom);
      return d;
   endfunction

   task automatic write_reg(pk3d_pkg::csr_idx_type idx,
                            logic [pk3d_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      do @(posedge clock); while (!csr.ready);
      apply_reg(idx, val);
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   // wait until every word is taken and answered, then let the block go quiet
   task automatic settle(int unsigned tail);
      int unsigned spins;
      spins = 0;
      while ((word_q.size() != 0 || req.valid || due_reports.size() != 0) && spins < 400000) begin
         @(posedge clock);
         spins++;
      end
      repeat (tail) @(posedge clock);
   endtask

   initial clock = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // accept side: predictor and result checks
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req.valid && req.ready;
         if (req_taken) begin
            step_grid(pk3d_pkg::req_kind_type'(req.req_type), req.density);
            words_taken++;
         end
         if (rsp.valid && rsp.ready) check_report();
      end
   end

   always @(negedge clock) begin
      grid_word_type w;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_taken) begin
         if (word_q.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
            w = word_q.pop_front();
            req.valid    <= 1'b1;
            req.req_type <= w.kind;
            req.density  <= w.dens;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp.ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && exams_taken >= 150 && word_q.size() >= 10) begin
         // long hold-off so the examine pipe backs up into the request side
         hold_done = 1'b1;
         hold_left = 399;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= calm || ($urandom_range(99) >= 25);
      end
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned                    phase;
      int unsigned                    sxv;
      int unsigned                    syv;
      int unsigned                    szv;
      int unsigned                    total;
      int unsigned                    n;
      int unsigned                    axis;
      int                             mode;
      logic [pk3d_pkg::DENSITY_W-1:0] base;
      logic [pk3d_pkg::DENSITY_W-1:0] floor_v;

      reset        = 1'b1;
      req.valid    = 1'b0;
      req.req_type = pk3d_pkg::REQ_LOAD;
      req.density  = '0;
      rsp.ready    = 1'b0;
      csr.valid    = 1'b0;
      csr.index    = pk3d_pkg::CSR_SIZE_X;
      csr.data     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single cell grid from zero sizes, top threshold, cell meets itself
      write_reg(pk3d_pkg::CSR_SIZE_X, 16'd0);
      write_reg(pk3d_pkg::CSR_SIZE_Y, 16'd0);
      write_reg(pk3d_pkg::CSR_SIZE_Z, 16'd0);
      write_reg(pk3d_pkg::CSR_MIN_PEAK, 16'hFFFF);
      push_word(pk3d_pkg::REQ_LOAD, 16'hFFFF);
      push_word(pk3d_pkg::REQ_EXAMINE, 16'h0000);
      push_word(pk3d_pkg::REQ_EXAMINE, 16'hFFFF);
      push_word(pk3d_pkg::REQ_LOAD, 16'h0000);
      push_word(pk3d_pkg::REQ_EXAMINE, 16'h1234);
      settle(40);

      // 2x2x1 grid of three equal cells and one lower, zero threshold, scan wraps past the last cell
      write_reg(pk3d_pkg::CSR_SIZE_X, 16'd2);
      write_reg(pk3d_pkg::CSR_SIZE_Y, 16'd2);
      write_reg(pk3d_pkg::CSR_SIZE_Z, 16'd1);
      write_reg(pk3d_pkg::CSR_MIN_PEAK, 16'h0000);
      push_word(pk3d_pkg::REQ_LOAD, 16'd7);
      push_word(pk3d_pkg::REQ_LOAD, 16'd7);
      push_word(pk3d_pkg::REQ_LOAD, 16'd3);
      push_word(pk3d_pkg::REQ_LOAD, 16'd7);
      repeat (5) push_word(pk3d_pkg::REQ_EXAMINE, 16'h0000);
      settle(40);

      // junk above the size bits, threshold in between, partial scan left behind
      write_reg(pk3d_pkg::CSR_SIZE_X, 16'h0381);
      write_reg(pk3d_pkg::CSR_SIZE_Y, 16'd1);
      write_reg(pk3d_pkg::CSR_SIZE_Z, 16'd3);
      write_reg(pk3d_pkg::CSR_MIN_PEAK, 16'h0100);
      push_word(pk3d_pkg::REQ_LOAD, 16'h00FF);
      push_word(pk3d_pkg::REQ_LOAD, 16'h0100);
      push_word(pk3d_pkg::REQ_LOAD, 16'h0100);
      push_word(pk3d_pkg::REQ_EXAMINE, 16'h0000);
      push_word(pk3d_pkg::REQ_EXAMINE, 16'h0000);

      phase = 0;
      while (pushed < WORD_GOAL) begin
         settle(40);
         case (phase)
            0: begin sxv = 1;  syv = 0; szv = 127; end
            1: begin sxv = 64; syv = 1; szv = 1;   end
            2: begin sxv = 0;  syv = 100; szv = 1; end
            default: begin
               if ($urandom_range(7) == 0) begin
                  axis = $urandom_range(2);
                  sxv  = (axis == 0) ? $urandom_range(20, 127) : $urandom_range(1);
                  syv  = (axis == 1) ? $urandom_range(20, 127) : $urandom_range(1);
                  szv  = (axis == 2) ? $urandom_range(20, 127) : $urandom_range(1);
               end else begin
                  sxv = $urandom_range(4);
                  syv = $urandom_range(4);
                  szv = $urandom_range(4);
               end
            end
         endcase
         mode = $urandom_range(2);
         base = pk3d_pkg::DENSITY_W'($urandom_range(65533));
         case ($urandom_range(7))
            0, 1:    floor_v = 16'h0000;
            2:       floor_v = 16'hFFFF;
            default: floor_v = (mode == 1) ? base + pk3d_pkg::DENSITY_W'($urandom_range(2))
                                           : pk3d_pkg::DENSITY_W'($urandom_range(65535));
         endcase
         write_reg(pk3d_pkg::CSR_SIZE_X, size_word(sxv));
         write_reg(pk3d_pkg::CSR_SIZE_Y, size_word(syv));
         write_reg(pk3d_pkg::CSR_SIZE_Z, size_word(szv));
         write_reg(pk3d_pkg::CSR_MIN_PEAK, floor_v);
         total = axis_len(pk3d_pkg::SIZE_W'(sxv)) * axis_len(pk3d_pkg::SIZE_W'(syv))
               * axis_len(pk3d_pkg::SIZE_W'(szv));
         // fill every cell in use before any examine
         for (int i = 0; i < total; i++)
            push_word(pk3d_pkg::REQ_LOAD, pick_density(mode, base));
         n = $urandom_range(1, 2 * total + 2);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 85)
               push_word(pk3d_pkg::REQ_EXAMINE,
                         pk3d_pkg::DENSITY_W'($urandom_range(65535)));
            else
               push_word(pk3d_pkg::REQ_LOAD, pick_density(mode, base));
         end
         phase++;
      end

      settle(60);
      if (due_reports.size() != 0)
         report_error($sformatf("%0d results never arrived", due_reports.size()));
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### filelist.f
rtl/pk3d_pkg.sv
rtl/pk3d_if.sv
rtl/periodic_3d_peak_finder.sv
rtl/pk3d_checker.sv
sim/tb.sv
